// File: rtl/core/pls_pkg.sv
// Shared types, codes and constants for the positional list store.
package pls_pkg;

    // Field widths fixed by the request and result formats
    localparam int OP_W     = 3;
    localparam int POS_W    = 8;
    localparam int VAL_W    = 32;
    localparam int STS_W    = 2;
    localparam int LEN_W    = 5;
    // A dump never emits more than this many elements
    localparam int DUMP_LIMIT = 16;

    // Opcodes
    localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_POS  = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_POS  = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP     = 3'd4;

    // Result status codes
    localparam logic [STS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STS_W-1:0] ST_BADPOS = 2'd2;
    localparam logic [STS_W-1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [VAL_W-1:0] element;
        logic [STS_W-1:0]        status;
        logic [LEN_W-1:0]        length;
        logic                    last;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_FINISH
    } t_state;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_COUNT,
        IDX_DELPOS,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_PREV,
        RD_NEXT
    } t_rd_sel;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    // Controller to datapath commands
    typedef struct packed {
        logic             cap;
        t_idx_op          idx_op;
        logic             rd_en;
        t_rd_sel          rd_sel;
        logic             wr_en;
        logic             wr_rdata;
        t_cnt_op          cnt_op;
        logic             emit;
        logic             emit_rdata;
        logic [STS_W-1:0] emit_status;
        logic             emit_last;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [OP_W-1:0] opcode;
        logic            ins_pos_ok;
        logic            del_pos_ok;
        logic            full;
        logic            empty;
        logic            at_tgt;
        logic            del_done;
        logic            dump_last;
    } t_sts;

    localparam t_cmd CMD_NOP = '{
        cap:         1'b0,
        idx_op:      IDX_HOLD,
        rd_en:       1'b0,
        rd_sel:      RD_IDX,
        wr_en:       1'b0,
        wr_rdata:    1'b0,
        cnt_op:      CNT_HOLD,
        emit:        1'b0,
        emit_rdata:  1'b0,
        emit_status: ST_OK,
        emit_last:   1'b0
    };

endpackage

// File: rtl/core/pls_ram.sv
// Generic single write, single read RAM with registered read data.
module pls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/pls_dp.sv
// Datapath: request register, cell memory, element count, cell index and result register.
module pls_dp #(
    parameter int CAPACITY = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pls_pkg::t_req i_req,
    input  pls_pkg::t_cmd i_cmd,
    output pls_pkg::t_sts o_sts,
    output logic          o_strobe,
    output pls_pkg::t_res o_res
);
    import pls_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    // Compare width wide enough for position, count and one more
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    t_req            r_req;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic [AW-1:0]   r_idx;
    logic [AW-1:0]   n_idx;
    logic [AW-1:0]   w_tgt;
    logic [AW-1:0]   w_del_idx;
    logic [AW-1:0]   w_rd_addr;
    logic [VAL_W-1:0] w_wr_data;
    logic [VAL_W-1:0] w_rd_data;
    logic [XW-1:0]   w_pos;
    logic [XW-1:0]   w_cnt;
    logic [XW-1:0]   w_idx1;
    logic [XW-1:0]   w_dump_n;
    logic            r_strobe;
    t_res            r_res;
    t_res            n_res;

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_req <= i_req;
        end
    end

    // Checks on the captured request against the current length
    always_comb begin
        w_pos     = XW'(r_req.position);
        w_cnt     = XW'(r_count);
        w_idx1    = XW'(r_idx) + XW'(1);
        w_dump_n  = (w_cnt > XW'(DUMP_LIMIT)) ? XW'(DUMP_LIMIT) : w_cnt;
        w_del_idx = AW'(r_req.position - POS_W'(1));
        case (r_req.opcode)
            OP_INS_HEAD: w_tgt = '0;
            OP_INS_TAIL: w_tgt = AW'(r_count);
            default:     w_tgt = w_del_idx;
        endcase
        o_sts.opcode     = r_req.opcode;
        o_sts.ins_pos_ok = (r_req.position != '0) && (w_pos <= w_cnt + XW'(1));
        o_sts.del_pos_ok = (r_req.position != '0) && (w_pos <= w_cnt);
        o_sts.full       = (w_cnt == XW'(CAPACITY));
        o_sts.empty      = (r_count == '0);
        o_sts.at_tgt     = (r_idx == w_tgt);
        o_sts.del_done   = (w_idx1 >= w_cnt);
        o_sts.dump_last  = (w_idx1 == w_dump_n);
    end

    // Cell index walks the shift or dump
    always_comb begin
        case (i_cmd.idx_op)
            IDX_COUNT:  n_idx = AW'(r_count);
            IDX_DELPOS: n_idx = w_del_idx;
            IDX_ZERO:   n_idx = '0;
            IDX_INC:    n_idx = r_idx + AW'(1);
            IDX_DEC:    n_idx = r_idx - AW'(1);
            default:    n_idx = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
    end

    // Element count
    always_comb begin
        case (i_cmd.cnt_op)
            CNT_INC: n_count = r_count + CW'(1);
            CNT_DEC: n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Cell memory addressing
    always_comb begin
        case (i_cmd.rd_sel)
            RD_PREV: w_rd_addr = r_idx - AW'(1);
            RD_NEXT: w_rd_addr = r_idx + AW'(1);
            default: w_rd_addr = r_idx;
        endcase
        w_wr_data = i_cmd.wr_rdata ? w_rd_data : VAL_W'(r_req.value);
    end

    pls_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_cells (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Result register
    always_comb begin
        n_res.element = i_cmd.emit_rdata ? signed'(w_rd_data) : '0;
        n_res.status  = i_cmd.emit_status;
        n_res.length  = LEN_W'(r_count);
        n_res.last    = i_cmd.emit_last;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

// File: rtl/core/pls_ctrl.sv
// Controller: sequences request checks, cell shifts, dumps and result strobes.
module pls_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  pls_pkg::t_sts i_sts,
    output logic          o_busy,
    output pls_pkg::t_cmd o_cmd
);
    import pls_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NOP;
        o_busy  = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_CHECK;
                end
            end
            S_CHECK: begin
                case (i_sts.opcode)
                    OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
                        o_cmd.emit_last = 1'b1;
                        if (i_sts.opcode == OP_INS_POS && !i_sts.ins_pos_ok) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = ST_BADPOS;
                            n_state           = S_IDLE;
                        end else if (i_sts.full) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = ST_FULL;
                            n_state           = S_IDLE;
                        end else begin
                            // start at the new tail cell and shift down to the target
                            o_cmd.idx_op = IDX_COUNT;
                            n_state      = S_INS_RD;
                        end
                    end
                    OP_DEL_POS: begin
                        if (!i_sts.del_pos_ok) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = ST_BADPOS;
                            o_cmd.emit_last   = 1'b1;
                            n_state           = S_IDLE;
                        end else begin
                            o_cmd.idx_op = IDX_DELPOS;
                            n_state      = S_DEL_RD;
                        end
                    end
                    OP_DUMP: begin
                        if (i_sts.empty) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = ST_EMPTY;
                            o_cmd.emit_last   = 1'b1;
                            n_state           = S_IDLE;
                        end else begin
                            o_cmd.idx_op = IDX_ZERO;
                            n_state      = S_DUMP_RD;
                        end
                    end
                    default: begin
                        // unused opcode: no change, plain ok
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_last = 1'b1;
                        n_state         = S_IDLE;
                    end
                endcase
            end
            S_INS_RD: begin
                if (i_sts.at_tgt) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.cnt_op = CNT_INC;
                    n_state      = S_FINISH;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_PREV;
                    n_state      = S_INS_WR;
                end
            end
            S_INS_WR: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_rdata = 1'b1;
                o_cmd.idx_op   = IDX_DEC;
                n_state        = S_INS_RD;
            end
            S_DEL_RD: begin
                if (i_sts.del_done) begin
                    o_cmd.cnt_op = CNT_DEC;
                    n_state      = S_FINISH;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_NEXT;
                    n_state      = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_rdata = 1'b1;
                o_cmd.idx_op   = IDX_INC;
                n_state        = S_DEL_RD;
            end
            S_DUMP_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_DUMP_OUT;
            end
            S_DUMP_OUT: begin
                // emit the cell read last cycle, fetch the next one
                o_cmd.emit       = 1'b1;
                o_cmd.emit_rdata = 1'b1;
                o_cmd.emit_last  = i_sts.dump_last;
                if (i_sts.dump_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_NEXT;
                    o_cmd.idx_op = IDX_INC;
                end
            end
            S_FINISH: begin
                o_cmd.emit      = 1'b1;
                o_cmd.emit_last = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/positional_list_store.sv
// Top level of the positional list store: controller plus datapath.
//
// Holds an ordered list of up to CAPACITY signed 32-bit values, packed head
// first in a single-port-write, registered-read cell RAM.
// Request channel: i_req (opcode, position, value) is taken on a rising edge
// with start high and busy low. busy stays high until the request's last
// result has been issued.
// Result channel: each result sits on o_res for one cycle with o_strobe high;
// o_res.last marks the final result of a request. The receiver cannot stall.
// Insert and delete move one cell at a time through the RAM port, a read
// state then a write state per cell, and a request gives a single result
// once its moves are done (rejected requests, unused opcodes and an empty
// dump answer straight from the check state).
// A dump of n elements shows them one element per cycle (n capped at 16).
// A new request can be taken in the cycle the last result is shown.
// Reset (synchronous, active low) empties the list and returns to idle; cell
// contents are not cleared, only the count.
module positional_list_store #(
    parameter int CAPACITY = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  pls_pkg::t_req i_req,
    output logic          o_strobe,
    output pls_pkg::t_res o_res
);
    import pls_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    pls_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    pls_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

endmodule

// File: rtl/core/pls_chk.sv
// Port-level checker for the positional list store, bound to the top level.
module pls_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_strobe,
    input pls_pkg::t_res o_res
);
    import pls_pkg::*;

    // A taken request keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request taken but block not busy");

    // Dump elements come back to back until the last one
    a_dump_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_res.last |=> o_strobe)
        else $error("gap inside a result stream");

    // A request's results never follow the last one directly
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_res.last |=> !o_strobe)
        else $error("result right after final result");

    // Error statuses only on a single, final result
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_res.status != ST_OK) |-> o_res.last)
        else $error("error status on a non-final result");

    // An empty dump reports no elements
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_res.status == ST_EMPTY) |-> (o_res.length == '0)
            && (o_res.element == '0))
        else $error("empty dump with nonzero length or element");

endmodule

bind positional_list_store pls_chk u_pls_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_res    (o_res)
);
